FILE: hdl/rlps_pkg.sv
package rlps_pkg;

	localparam int DUTY_BITS_DEFAULT = 16;
	localparam int OUT_DUTY_BITS     = 16;
	localparam int CFG_DATA_BITS     = 16;
	localparam int CFG_ADDR_BITS     = 1;

	localparam logic [15:0] PWM_PERIOD_RESET = 16'd20000;

	localparam logic [CFG_ADDR_BITS-1:0] REG_PWM_PERIOD = 1'b0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_LEDS_READY = 1'b1;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_OFF   = 2'd2;

	localparam logic [3:0] PAT_INIT_FAIL    = 4'd0;
	localparam logic [3:0] PAT_ADV_FAIL     = 4'd1;
	localparam logic [3:0] PAT_SENSOR       = 4'd2;
	localparam logic [3:0] PAT_BREATHING    = 4'd3;
	localparam logic [3:0] PAT_CONNECTED    = 4'd4;
	localparam logic [3:0] PAT_CONN_FAIL    = 4'd5;
	localparam logic [3:0] PAT_DISCONNECTED = 4'd6;
	localparam logic [3:0] PAT_DIS_TX       = 4'd7;
	localparam logic [3:0] PAT_NUS_RX       = 4'd8;
	localparam logic [3:0] PAT_LAST         = PAT_NUS_RX;

	localparam logic [7:0] INIT_FAIL_WRAP = 8'd140;
	localparam logic [7:0] ADV_FAIL_WRAP  = 8'd40;
	localparam logic [7:0] BREATH_LAST    = 8'd80;

	localparam int BREATH_PERIOD = 40;
	localparam int BREATH_DIV    = 20;

	typedef struct packed {
		logic [1:0] action;
		logic [3:0] pattern_id;
	} rlps_in_t;

	typedef struct packed {
		logic [OUT_DUTY_BITS-1:0] red_duty;
		logic [OUT_DUTY_BITS-1:0] green_duty;
		logic [OUT_DUTY_BITS-1:0] blue_duty;
		logic                     status_led;
		logic                     playing;
	} rlps_out_t;

	typedef struct packed {
		logic [3:0] pattern;
		logic [7:0] step;
		logic       running;
		logic       led;
	} rlps_ctrl_t;

endpackage

FILE: hdl/rgb_led_pattern_sequencer_core.sv
// Plays one of nine LED patterns on three PWM duty values and a plain status LED.
// A transaction carries a tick, a start with a pattern number, or an off command;
// each one returns exactly one result transaction with the duties, the status LED
// and whether a pattern is still playing. The block takes one transaction every
// cycle while out_ready lets results drain; an accepted input is held in the input
// register, passes through the step logic into the result register, and the result
// waits there while out_ready is low. The longest path is the breathing step, a
// single multiply of the period by a constant-table reciprocal of twenty. Write
// pwm_period and leds_ready only while no transaction is in flight.
module rgb_led_pattern_sequencer_core import rlps_pkg::*; #(
	parameter int DUTY_BITS = DUTY_BITS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  rlps_in_t                 in_data,
	output logic                     out_valid,
	input  logic                     out_ready,
	output rlps_out_t                out_data,
	input  logic                     cfg_we,
	input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	logic                      valid_s1;
	rlps_in_t                  item_s1;
	logic                      adv;
	logic [15:0]               pwm_period_q;
	logic                      leds_ready_q;
	rlps_ctrl_t                ctrl_q;
	rlps_ctrl_t                ctrl_nxt;
	logic [2:0][DUTY_BITS-1:0] duty_q;
	logic [2:0][DUTY_BITS-1:0] duty_nxt;
	logic                      out_valid_q;
	rlps_out_t                 out_data_q;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q <= PWM_PERIOD_RESET;
			leds_ready_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_PWM_PERIOD: pwm_period_q <= cfg_wdata[15:0];
				REG_LEDS_READY: leds_ready_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	rlps_step #(
		.DUTY_BITS(DUTY_BITS)
	) u_step (
		.item      (item_s1),
		.leds_ready(leds_ready_q),
		.period    (DUTY_BITS'(pwm_period_q)),
		.ctrl      (ctrl_q),
		.duty      (duty_q),
		.ctrl_nxt  (ctrl_nxt),
		.duty_nxt  (duty_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
			duty_q <= '0;
		end else if (adv) begin
			ctrl_q <= ctrl_nxt;
			duty_q <= duty_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q.red_duty   <= OUT_DUTY_BITS'(duty_nxt[0]);
			out_data_q.green_duty <= OUT_DUTY_BITS'(duty_nxt[1]);
			out_data_q.blue_duty  <= OUT_DUTY_BITS'(duty_nxt[2]);
			out_data_q.status_led <= ctrl_nxt.led;
			out_data_q.playing    <= ctrl_nxt.running;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

FILE: hdl/rlps_step.sv
module rlps_step import rlps_pkg::*; #(
	parameter int DUTY_BITS = DUTY_BITS_DEFAULT
) (
	input  rlps_in_t                         item,
	input  logic                             leds_ready,
	input  logic [DUTY_BITS-1:0]             period,
	input  rlps_ctrl_t                       ctrl,
	input  logic [2:0][DUTY_BITS-1:0]        duty,
	output rlps_ctrl_t                       ctrl_nxt,
	output logic [2:0][DUTY_BITS-1:0]        duty_nxt
);

	localparam int SHIFT      = DUTY_BITS + 5;
	localparam int PROD_BITS  = DUTY_BITS + SHIFT;
	localparam int RECIP_ROWS = BREATH_DIV + 1;

	logic [SHIFT-1:0]     recip [RECIP_ROWS];
	logic                 start_ok;
	logic                 off_ok;
	logic                 do_run;
	logic [3:0]           pat;
	logic [7:0]           s;
	logic [5:0]           ph;
	logic [4:0]           k;
	logic [PROD_BITS-1:0] prod;
	logic [DUTY_BITS-1:0] breath;

	// Each row holds ceil(k * 2^SHIFT / 20), so the product shifted down equals
	// period * k / 20 truncated. The full-scale row is taken from the period itself.
	for (genvar i = 0; i < RECIP_ROWS; i++) begin : g_recip
		if (i == BREATH_DIV) begin : g_full
			assign recip[i] = '0;
		end else begin : g_frac
			assign recip[i] = SHIFT'(((64'(i) << SHIFT) + 64'(BREATH_DIV - 1)) / BREATH_DIV);
		end
	end

	assign start_ok = (item.action == ACT_START) && leds_ready && (item.pattern_id <= PAT_LAST);
	assign off_ok   = (item.action == ACT_OFF) && leds_ready;
	assign do_run   = start_ok || ((item.action == ACT_TICK) && ctrl.running);
	assign pat      = start_ok ? item.pattern_id : ctrl.pattern;
	assign s        = start_ok ? 8'd0 : ctrl.step;

	always_comb begin
		if (s < 8'(BREATH_PERIOD)) begin
			ph = s[5:0];
		end else if (s < BREATH_LAST) begin
			ph = 6'(s - 8'(BREATH_PERIOD));
		end else begin
			ph = '0;
		end
	end

	assign k      = (ph < 6'(BREATH_DIV)) ? ph[4:0] : 5'(6'(BREATH_PERIOD) - ph);
	assign prod   = PROD_BITS'(period) * PROD_BITS'(recip[k]);
	assign breath = (k == 5'(BREATH_DIV)) ? period : DUTY_BITS'(prod >> SHIFT);

	always_comb begin
		logic                 put;
		logic                 run_step;
		logic                 led_nxt;
		logic [7:0]           s_nxt;
		logic [DUTY_BITS-1:0] r;
		logic [DUTY_BITS-1:0] g;
		logic [DUTY_BITS-1:0] b;

		put      = 1'b0;
		run_step = 1'b1;
		led_nxt  = ctrl.led;
		s_nxt    = s + 8'd1;
		r        = '0;
		g        = '0;
		b        = '0;

		case (pat)
			PAT_INIT_FAIL: begin
				if (s == 8'd0) begin
					put = 1'b1;
					r   = period;
				end else if (s == ADV_FAIL_WRAP) begin
					put = 1'b1;
				end else if (s == INIT_FAIL_WRAP) begin
					s_nxt = 8'd0;
				end
			end
			PAT_ADV_FAIL: begin
				if (s inside {8'd0, 8'd8}) begin
					put = 1'b1;
					r   = period;
				end else if (s inside {8'd4, 8'd12}) begin
					put = 1'b1;
				end else if (s == ADV_FAIL_WRAP) begin
					s_nxt = 8'd0;
				end
			end
			PAT_SENSOR: begin
				put = 1'b1;
				if (s[0]) begin
					r = period;
					g = period;
				end
			end
			PAT_BREATHING: begin
				put = 1'b1;
				if (s == BREATH_LAST) begin
					run_step = 1'b0;
				end else begin
					g = breath;
					b = breath >> 1;
				end
			end
			PAT_CONNECTED: begin
				put = 1'b1;
				if (s inside {8'd0, 8'd2, 8'd4, 8'd6}) begin
					b = period;
				end else if (s == 8'd7) begin
					run_step = 1'b0;
					led_nxt  = ~ctrl.led;
				end
			end
			PAT_CONN_FAIL: begin
				if (s inside {8'd0, 8'd8, 8'd16}) begin
					put = 1'b1;
					r   = period;
				end else if (s inside {8'd4, 8'd12, 8'd20}) begin
					put      = 1'b1;
					run_step = 1'b0;
					led_nxt  = 1'b0;
				end
			end
			PAT_DISCONNECTED: begin
				if (s == 8'd0) begin
					put = 1'b1;
					b   = period;
				end else if (s == 8'd2) begin
					put = 1'b1;
					r   = period;
				end else if (s == 8'd4) begin
					put      = 1'b1;
					run_step = 1'b0;
					led_nxt  = 1'b0;
				end
			end
			PAT_DIS_TX: begin
				put = 1'b1;
				if (s inside {8'd0, 8'd2}) begin
					r = period;
					g = period >> 2;
					b = period >> 1;
				end else if (s == 8'd3) begin
					run_step = 1'b0;
				end
			end
			PAT_NUS_RX: begin
				put = 1'b1;
				if (s inside {8'd0, 8'd2, 8'd4, 8'd6}) begin
					r = period;
					b = period;
				end else if (s == 8'd7) begin
					run_step = 1'b0;
				end
			end
			default: begin
				run_step = 1'b0;
			end
		endcase

		ctrl_nxt = ctrl;
		duty_nxt = duty;
		if (off_ok) begin
			ctrl_nxt = '0;
			duty_nxt = '0;
		end else if (do_run) begin
			ctrl_nxt.pattern = pat;
			ctrl_nxt.running = run_step;
			ctrl_nxt.led     = led_nxt;
			ctrl_nxt.step    = run_step ? s_nxt : s;
			if (put) begin
				duty_nxt[0] = r;
				duty_nxt[1] = g;
				duty_nxt[2] = b;
			end
		end
	end

endmodule
